// ----- rtl/core/lsp_pkg.sv -----
// Shared types, codes and constants for the Loop subdivision point rule unit.
// No dependencies.
`default_nettype none

package lsp_pkg;

    localparam int COORD_WIDTH        = 32;
    localparam int FRAC_BITS          = 16;
    localparam int MAX_DEGREE_DEFAULT = 32;
    localparam int ROM_DEPTH          = 64;
    localparam int ROM_IDX_W          = 6;
    localparam int W_WIDTH            = FRAC_BITS + 1;

    // command codes
    localparam logic [1:0] CMD_CENTRE    = 2'd0;
    localparam logic [1:0] CMD_NEIGHBOUR = 2'd1;
    localparam logic [1:0] CMD_ENDPOINT  = 2'd2;
    localparam logic [1:0] CMD_OPPOSITE  = 2'd3;

    // status / fault codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_MALFORMED = 2'd1;
    localparam logic [1:0] ST_OVERFLOW  = 2'd2;
    localparam logic [1:0] ST_SATURATED = 2'd3;

    // Q1.FRAC_BITS weights
    localparam logic [W_WIDTH-1:0] W_ONE         = W_WIDTH'(1) << FRAC_BITS;
    localparam logic [W_WIDTH-1:0] W_HALF        = W_WIDTH'(1) << (FRAC_BITS - 1);
    localparam logic [W_WIDTH-1:0] W_EIGHTH      = W_WIDTH'(1) << (FRAC_BITS - 3);
    localparam logic [W_WIDTH-1:0] W_THREE_EIGHT = W_WIDTH'(3) << (FRAC_BITS - 3);
    localparam logic [W_WIDTH-1:0] W_THREE_QUART = W_WIDTH'(3) << (FRAC_BITS - 2);
    localparam logic [W_WIDTH-1:0] W_ZERO        = '0;

    localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FACTOR,
        S_WEIGHT,
        S_MULA,
        S_MULB,
        S_ACC,
        S_ROUND,
        S_OUT
    } seq_state_t;

    typedef struct packed {
        logic       is_edge;
        logic [1:0] fault;
        logic       few_nb;
        logic       has_opp;
    } stencil_info_t;

endpackage

`default_nettype wire

// ----- rtl/core/lsp_accum.sv -----
// Stencil accumulator: collects centre, endpoint sum, neighbour sum, counts and faults.
// Depends on lsp_pkg.
`default_nettype none

module lsp_accum
    import lsp_pkg::*;
#(
    parameter int MAX_DEGREE = MAX_DEGREE_DEFAULT,
    parameter int CNT_W      = $clog2(MAX_DEGREE + 1),
    parameter int SUM_W      = COORD_WIDTH + CNT_W
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           accept,
    input  wire logic                           clear,
    input  wire logic [1:0]                     command,
    input  wire logic signed [COORD_WIDTH-1:0]  coord_x,
    input  wire logic signed [COORD_WIDTH-1:0]  coord_y,
    input  wire logic signed [COORD_WIDTH-1:0]  coord_z,
    output logic signed [COORD_WIDTH-1:0]       centre    [3],
    output logic signed [COORD_WIDTH+1:0]       esum      [3],
    output logic signed [SUM_W-1:0]             nsum      [3],
    output logic [CNT_W-1:0]                    count,
    output stencil_info_t                       info
);

    logic signed [COORD_WIDTH-1:0] pt [3];
    logic signed [COORD_WIDTH-1:0] centre_reg [3];
    logic signed [COORD_WIDTH-1:0] centre_next [3];
    logic signed [COORD_WIDTH+1:0] esum_reg [3];
    logic signed [COORD_WIDTH+1:0] esum_next [3];
    logic signed [SUM_W-1:0]       nsum_reg [3];
    logic signed [SUM_W-1:0]       nsum_next [3];
    logic [CNT_W-1:0]              count_reg, count_next;
    logic [1:0]                    cs_reg, cs_next;
    logic [1:0]                    ep_reg, ep_next;
    logic                          edge_reg, edge_next;
    logic [1:0]                    fault_reg, fault_next;
    logic                          kind;
    logic                          empty;
    logic                          edge_eff;
    logic                          shape_bad;

    assign pt[0] = coord_x;
    assign pt[1] = coord_y;
    assign pt[2] = coord_z;

    assign kind     = command[1];
    assign empty    = (cs_reg == 2'd0) && (ep_reg == 2'd0) && (count_reg == '0)
                      && (fault_reg == ST_OK);
    assign edge_eff = empty ? kind : edge_reg;

    always_comb
    begin
        centre_next = centre_reg;
        esum_next   = esum_reg;
        nsum_next   = nsum_reg;
        count_next  = count_reg;
        cs_next     = cs_reg;
        ep_next     = ep_reg;
        edge_next   = edge_reg;
        fault_next  = fault_reg;
        if (accept)
        begin
            edge_next = edge_eff;
            if (edge_eff != kind)
            begin
                fault_next = ST_MALFORMED;
            end
            else
            begin
                case (command)
                    CMD_CENTRE:
                    begin
                        if (cs_reg != 2'd0)
                            fault_next = ST_MALFORMED;
                        else
                            centre_next = pt;
                        if (cs_reg != 2'd3)
                            cs_next = cs_reg + 2'd1;
                    end
                    CMD_ENDPOINT:
                    begin
                        if (ep_reg >= 2'd2)
                            fault_next = ST_MALFORMED;
                        else
                            for (int i = 0; i < 3; i++)
                                esum_next[i] = esum_reg[i] + (COORD_WIDTH+2)'(pt[i]);
                        if (ep_reg != 2'd3)
                            ep_next = ep_reg + 2'd1;
                    end
                    default:
                    begin
                        if (count_reg >= CNT_W'(MAX_DEGREE))
                        begin
                            if (fault_reg == ST_OK)
                                fault_next = ST_OVERFLOW;
                        end
                        else
                        begin
                            for (int i = 0; i < 3; i++)
                                nsum_next[i] = nsum_reg[i] + SUM_W'(pt[i]);
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                endcase
            end
        end
        if (clear)
        begin
            for (int i = 0; i < 3; i++)
            begin
                centre_next[i] = '0;
                esum_next[i]   = '0;
                nsum_next[i]   = '0;
            end
            count_next = '0;
            cs_next    = '0;
            ep_next    = '0;
            edge_next  = 1'b0;
            fault_next = ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                centre_reg[i] <= '0;
                esum_reg[i]   <= '0;
                nsum_reg[i]   <= '0;
            end
            count_reg <= '0;
            cs_reg    <= '0;
            ep_reg    <= '0;
            edge_reg  <= 1'b0;
            fault_reg <= ST_OK;
        end
        else
        begin
            centre_reg <= centre_next;
            esum_reg   <= esum_next;
            nsum_reg   <= nsum_next;
            count_reg  <= count_next;
            cs_reg     <= cs_next;
            ep_reg     <= ep_next;
            edge_reg   <= edge_next;
            fault_reg  <= fault_next;
        end
    end

    // missing centre or endpoint at close
    assign shape_bad = edge_reg ? (ep_reg != 2'd2) : (cs_reg != 2'd1);

    assign centre       = centre_reg;
    assign esum         = esum_reg;
    assign nsum         = nsum_reg;
    assign count        = count_reg;
    assign info.is_edge = edge_reg;
    assign info.fault   = (fault_reg != ST_OK) ? fault_reg
                        : (shape_bad ? ST_MALFORMED : ST_OK);
    assign info.few_nb  = count_reg < CNT_W'(3);
    assign info.has_opp = count_reg != '0;

endmodule

`default_nettype wire

// ----- rtl/core/lsp_mul.sv -----
// Shared registered multiplier: signed operand (coordinate sum or count) times unsigned weight.
// Depends on lsp_pkg.
`default_nettype none

module lsp_mul
    import lsp_pkg::*;
#(
    parameter int A_W = COORD_WIDTH + 6
)
(
    input  wire logic                      clk,
    input  wire logic signed [A_W-1:0]     mul_a,
    input  wire logic [W_WIDTH-1:0]        mul_b,
    output logic signed [A_W+W_WIDTH:0]    prod
);

    logic signed [W_WIDTH:0]     b_signed;
    logic signed [A_W+W_WIDTH:0] prod_reg;

    assign b_signed = {1'b0, mul_b};

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * b_signed;
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

// ----- rtl/core/loop_subdivision_point_rule_unit.sv -----
// Top level of the Loop subdivision point rule unit: sequencer, weights, rounding, output.
// Depends on lsp_pkg, lsp_accum and lsp_mul.
//
// Requests are taken without stall while a stencil is open. The request marked last
// closes the stencil: the unit then stalls its input and weighs the stencil on one shared
// multiplier: S_FACTOR and S_WEIGHT form the weight pair, then each coordinate passes
// through S_MULA, S_MULB, S_ACC and S_ROUND (two products, accumulate, round and
// saturate) before the new point shows in S_OUT; a faulted stencil skips to S_OUT.
// The point is held until taken, and the next stencil is accepted in the cycle after that.
`default_nettype none

module loop_subdivision_point_rule_unit
    import lsp_pkg::*;
#(
    parameter int MAX_DEGREE = MAX_DEGREE_DEFAULT
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [1:0]                     command,
    input  wire logic signed [COORD_WIDTH-1:0]  coord_x,
    input  wire logic signed [COORD_WIDTH-1:0]  coord_y,
    input  wire logic signed [COORD_WIDTH-1:0]  coord_z,
    input  wire logic                           last,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic signed [COORD_WIDTH-1:0]       new_x,
    output logic signed [COORD_WIDTH-1:0]       new_y,
    output logic signed [COORD_WIDTH-1:0]       new_z,
    output logic [1:0]                          status
);

    localparam int CNT_W = $clog2(MAX_DEGREE + 1);
    localparam int SUM_W = COORD_WIDTH + CNT_W;
    localparam int PW    = SUM_W + W_WIDTH + 1;
    localparam int AW    = PW + 1;
    localparam logic signed [AW-1:0] HI_LIM =
        {{(AW-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [AW-1:0] LO_LIM =
        {{(AW-COORD_WIDTH+1){1'b1}}, {(COORD_WIDTH-1){1'b0}}};
    localparam logic signed [AW-1:0] RND_HALF = AW'(1) << (FRAC_BITS - 1);

    logic signed [COORD_WIDTH-1:0] centre [3];
    logic signed [COORD_WIDTH+1:0] esum [3];
    logic signed [SUM_W-1:0]       nsum [3];
    logic [CNT_W-1:0]              count;
    stencil_info_t                 info;

    seq_state_t                    state_reg, state_next;
    logic [1:0]                    axis_reg, axis_next;
    logic [W_WIDTH-1:0]            wa_reg, wa_next;
    logic [W_WIDTH-1:0]            wb_reg, wb_next;
    logic                          beta_reg, beta_next;
    logic signed [AW-1:0]          acc_reg, acc_next;
    logic signed [COORD_WIDTH-1:0] res_reg [3];
    logic signed [COORD_WIDTH-1:0] res_next [3];
    logic [1:0]                    status_reg, status_next;

    logic                          in_accept;
    logic                          clear;
    logic signed [SUM_W-1:0]       mul_a;
    logic [W_WIDTH-1:0]            mul_b;
    logic signed [PW-1:0]          prod;
    logic [W_WIDTH-1:0]            beta;
    logic signed [AW-1:0]          rnd_sum;
    logic signed [AW-1:0]          rnd;
    wire logic [ROM_DEPTH*W_WIDTH-1:0] beta_rom;

    assign in_accept = in_valid && !in_stall;
    assign clear     = (state_reg == S_OUT) && !out_stall;

    lsp_accum #(
        .MAX_DEGREE (MAX_DEGREE),
        .CNT_W      (CNT_W),
        .SUM_W      (SUM_W)
    ) u_accum (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (in_accept),
        .clear   (clear),
        .command (command),
        .coord_x (coord_x),
        .coord_y (coord_y),
        .coord_z (coord_z),
        .centre  (centre),
        .esum    (esum),
        .nsum    (nsum),
        .count   (count),
        .info    (info)
    );

    lsp_mul #(
        .A_W (SUM_W)
    ) u_mul (
        .clk   (clk),
        .mul_a (mul_a),
        .mul_b (mul_b),
        .prod  (prod)
    );

    // beta(n) = (5/8 - (3/8 + cos(2pi/n)/4)^2) / n, rounded half up to Q0.FRAC_BITS;
    // cos by a 12-term series in Q2.30
    for (genvar n = 0; n < ROM_DEPTH; n++)
    begin : g_beta
        if (n < 3)
        begin : g_none
            assign beta_rom[n*W_WIDTH +: W_WIDTH] = W_ZERO;
        end
        else
        begin : g_entry
            localparam longint unsigned X    = TWO_PI_Q30 / 64'(n);
            localparam longint unsigned X2   = (X * X) >> 30;
            localparam longint unsigned T1   = (((64'd1 << 30) * X2) >> 30) / 64'd2;
            localparam longint unsigned T2   = ((T1 * X2) >> 30) / 64'd12;
            localparam longint unsigned T3   = ((T2 * X2) >> 30) / 64'd30;
            localparam longint unsigned T4   = ((T3 * X2) >> 30) / 64'd56;
            localparam longint unsigned T5   = ((T4 * X2) >> 30) / 64'd90;
            localparam longint unsigned T6   = ((T5 * X2) >> 30) / 64'd132;
            localparam longint unsigned T7   = ((T6 * X2) >> 30) / 64'd182;
            localparam longint unsigned T8   = ((T7 * X2) >> 30) / 64'd240;
            localparam longint unsigned T9   = ((T8 * X2) >> 30) / 64'd306;
            localparam longint unsigned T10  = ((T9 * X2) >> 30) / 64'd380;
            localparam longint unsigned T11  = ((T10 * X2) >> 30) / 64'd462;
            localparam longint unsigned T12  = ((T11 * X2) >> 30) / 64'd552;
            localparam longint          COSV = (longint'(1) << 30)
                - longint'(T1) + longint'(T2) - longint'(T3) + longint'(T4)
                - longint'(T5) + longint'(T6) - longint'(T7) + longint'(T8)
                - longint'(T9) + longint'(T10) - longint'(T11) + longint'(T12);
            localparam longint unsigned UA   = 64'd1610612736 + $unsigned(COSV);
            localparam longint unsigned NUM  = (64'd5 << 61) - UA * UA;
            localparam longint unsigned DEN  = 64'(n) << (64 - FRAC_BITS);
            localparam longint unsigned BETA = (NUM + (DEN >> 1)) / DEN;
            assign beta_rom[n*W_WIDTH +: W_WIDTH] = W_WIDTH'(BETA);
        end
    end

    assign beta = beta_rom[ROM_IDX_W'(count)*W_WIDTH +: W_WIDTH];

    always_comb
    begin
        unique case (state_reg)
            S_FACTOR:
            begin
                mul_a = SUM_W'($unsigned(count));
                mul_b = beta;
            end
            S_MULA:
            begin
                mul_a = info.is_edge ? SUM_W'(esum[axis_reg]) : SUM_W'(centre[axis_reg]);
                mul_b = wa_reg;
            end
            default:
            begin
                mul_a = nsum[axis_reg];
                mul_b = wb_reg;
            end
        endcase
    end

    assign rnd_sum = acc_reg + RND_HALF;
    assign rnd     = rnd_sum >>> FRAC_BITS;

    always_comb
    begin
        state_next  = state_reg;
        axis_next   = axis_reg;
        wa_next     = wa_reg;
        wb_next     = wb_reg;
        beta_next   = beta_reg;
        acc_next    = acc_reg;
        res_next    = res_reg;
        status_next = status_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept && last)
                    state_next = S_FACTOR;
            end
            S_FACTOR:
            begin
                axis_next   = 2'd0;
                status_next = info.fault;
                beta_next   = 1'b0;
                if (info.fault != ST_OK)
                begin
                    for (int i = 0; i < 3; i++)
                        res_next[i] = '0;
                    state_next = S_OUT;
                end
                else
                begin
                    if (info.is_edge)
                    begin
                        wa_next = info.has_opp ? W_THREE_EIGHT : W_HALF;
                        wb_next = info.has_opp ? W_EIGHTH : W_ZERO;
                    end
                    else if (info.few_nb)
                    begin
                        wa_next = W_THREE_QUART;
                        wb_next = W_EIGHTH;
                    end
                    else
                    begin
                        wb_next   = beta;
                        beta_next = 1'b1;
                    end
                    state_next = S_WEIGHT;
                end
            end
            S_WEIGHT:
            begin
                if (beta_reg)
                    wa_next = W_ONE - prod[W_WIDTH-1:0];
                state_next = S_MULA;
            end
            S_MULA:
            begin
                state_next = S_MULB;
            end
            S_MULB:
            begin
                acc_next   = AW'(prod);
                state_next = S_ACC;
            end
            S_ACC:
            begin
                acc_next   = acc_reg + AW'(prod);
                state_next = S_ROUND;
            end
            S_ROUND:
            begin
                if (rnd > HI_LIM)
                begin
                    res_next[axis_reg] = HI_LIM[COORD_WIDTH-1:0];
                    status_next        = ST_SATURATED;
                end
                else if (rnd < LO_LIM)
                begin
                    res_next[axis_reg] = LO_LIM[COORD_WIDTH-1:0];
                    status_next        = ST_SATURATED;
                end
                else
                begin
                    res_next[axis_reg] = rnd[COORD_WIDTH-1:0];
                end
                axis_next  = axis_reg + 2'd1;
                state_next = (axis_reg == 2'd2) ? S_OUT : S_MULA;
            end
            S_OUT:
            begin
                if (!out_stall)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        axis_reg   <= axis_next;
        wa_reg     <= wa_next;
        wb_reg     <= wb_next;
        beta_reg   <= beta_next;
        acc_reg    <= acc_next;
        res_reg    <= res_next;
        status_reg <= status_next;
    end

    assign in_stall  = state_reg != S_IDLE;
    assign out_valid = state_reg == S_OUT;
    assign new_x     = res_reg[0];
    assign new_y     = res_reg[1];
    assign new_z     = res_reg[2];
    assign status    = status_reg;

endmodule

`default_nettype wire

// ----- rtl/core/lsp_checker.sv -----
// Port-level checks for loop_subdivision_point_rule_unit, bound to the top level.
// Depends on lsp_pkg.
`default_nettype none

module lsp_checker
    import lsp_pkg::*;
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    input  wire logic                           in_stall,
    input  wire logic                           last,
    input  wire logic                           out_valid,
    input  wire logic                           out_stall,
    input  wire logic signed [COORD_WIDTH-1:0]  new_x,
    input  wire logic signed [COORD_WIDTH-1:0]  new_y,
    input  wire logic signed [COORD_WIDTH-1:0]  new_z,
    input  wire logic [1:0]                     status
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(new_x) && $stable(new_y)
            && $stable(new_z) && $stable(status))
        else $error("result changed while stalled");

    a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_MALFORMED || status == ST_OVERFLOW)
            |-> new_x == '0 && new_y == '0 && new_z == '0)
        else $error("faulted result carries nonzero point");

    a_stall_on_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input open while a result is pending");

    a_close_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && last |=> in_stall)
        else $error("input not stalled after closing request");

endmodule

bind loop_subdivision_point_rule_unit lsp_checker u_lsp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .last      (last),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .new_x     (new_x),
    .new_y     (new_y),
    .new_z     (new_z),
    .status    (status)
);

`default_nettype wire
